[rtl/key_payload_quicksort_unit_assert.svh]
// Assertion macros shared by the key/payload quicksort checker.
`ifndef KEY_PAYLOAD_QUICKSORT_UNIT_ASSERT_SVH
`define KEY_PAYLOAD_QUICKSORT_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KPQS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kpqs same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define KPQS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kpqs next-cycle check failed");

`endif

[rtl/kpqs_pkg.sv]
// Shared constants for the key/payload quicksort unit.
`default_nettype none

package kpqs_pkg;

	localparam int KEY_W = 32;
	localparam int TAG_W = 16;

	localparam int DEPTH_DEF    = 64;
	localparam int KEY_BITS_DEF = 32;
	localparam int TAG_BITS_DEF = 16;

endpackage

`default_nettype wire

[rtl/key_payload_quicksort_unit.sv]
// Items load at one per cycle while item_ready is high; up to DEPTH are kept and later
// ones are dropped, though a dropped item flagged last_item still closes the set. If
// more than one item is kept, the closing item starts an in-place quicksort (middle
// pivot, Lomuto partition, explicit range stack) during which item_ready stays low. The
// sort is paced by the single write port of the item store. Sorted pairs then leave
// one at a time, each held until taken, ascending by signed key, with final_result set
// on the last one; loading of the next set resumes once the last pair sits in the
// output register.
`default_nettype none

module key_payload_quicksort_unit #(
	parameter int DEPTH    = kpqs_pkg::DEPTH_DEF,
	parameter int KEY_BITS = kpqs_pkg::KEY_BITS_DEF,
	parameter int TAG_BITS = kpqs_pkg::TAG_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              item_valid,
	output logic                                   item_ready,
	input  wire logic signed [kpqs_pkg::KEY_W-1:0] key_value,
	input  wire logic        [kpqs_pkg::TAG_W-1:0] tag_value,
	input  wire logic                              last_item,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output logic signed      [kpqs_pkg::KEY_W-1:0] sorted_key,
	output logic             [kpqs_pkg::TAG_W-1:0] sorted_tag,
	output logic                                   final_result
);

	localparam int IDX_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam int WORD_W   = KEY_BITS + TAG_BITS;
	localparam int RANGE_W  = 2 * IDX_BITS;

	typedef enum logic [3:0] {
		S_LOAD,
		S_POP,
		S_POP_WAIT,
		S_RANGE,
		S_SW_RD,
		S_SW_W1,
		S_SW_W2,
		S_SCAN,
		S_SCAN_CMP,
		S_FINISH,
		S_OUT,
		S_OUT_WAIT
	} state_t;

	state_t                      state_q;
	state_t                      ret_q;
	logic [CNT_BITS-1:0]         count_q;
	logic [CNT_BITS-1:0]         n_q;
	logic [CNT_BITS-1:0]         sp_q;
	logic [CNT_BITS-1:0]         k_q;
	logic [CNT_BITS-1:0]         out_idx_q;
	logic [IDX_BITS-1:0]         lo_q;
	logic [IDX_BITS-1:0]         hi_q;
	logic [IDX_BITS-1:0]         last_q;
	logic [IDX_BITS-1:0]         sw_a_q;
	logic [IDX_BITS-1:0]         sw_b_q;
	logic [WORD_W-1:0]           tmp_q;
	logic signed [KEY_BITS-1:0]  pivot_q;
	logic                        result_valid_q;
	logic signed [kpqs_pkg::KEY_W-1:0] sorted_key_q;
	logic [kpqs_pkg::TAG_W-1:0]  sorted_tag_q;
	logic                        final_result_q;

	logic                        item_acc;
	logic                        has_room;
	logic [CNT_BITS-1:0]         n_next;
	logic signed [KEY_BITS-1:0]  key_in;
	logic [TAG_BITS-1:0]         tag_in;
	logic [IDX_BITS-1:0]         mid;
	logic [IDX_BITS-1:0]         last_inc;
	logic                        push_tail;

	logic                        ram_we;
	logic [IDX_BITS-1:0]         ram_waddr;
	logic [WORD_W-1:0]           ram_wdata;
	logic [IDX_BITS-1:0]         ram_raddr_a;
	logic [WORD_W-1:0]           ram_rdata_a;
	logic [WORD_W-1:0]           ram_rdata_b;
	logic signed [KEY_BITS-1:0]  rd_key_a;
	logic [TAG_BITS-1:0]         rd_tag_a;
	logic signed [KEY_BITS-1:0]  rd_key_b;

	logic                        stk_we;
	logic [IDX_BITS-1:0]         stk_waddr;
	logic [RANGE_W-1:0]          stk_wdata;
	logic [IDX_BITS-1:0]         stk_raddr;
	logic [RANGE_W-1:0]          stk_rdata;

	assign item_ready   = (state_q == S_LOAD);
	assign item_acc     = item_valid && item_ready;
	assign has_room     = (count_q < CNT_BITS'(DEPTH));
	assign n_next       = has_room ? count_q + CNT_BITS'(1) : count_q;
	assign key_in       = KEY_BITS'(key_value);
	assign tag_in       = TAG_BITS'(tag_value);
	assign mid          = IDX_BITS'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign last_inc     = last_q + IDX_BITS'(1);
	assign push_tail    = ({1'b0, last_q} + (IDX_BITS + 1)'(1)) < {1'b0, hi_q};

	assign rd_key_a     = ram_rdata_a[WORD_W-1:TAG_BITS];
	assign rd_tag_a     = ram_rdata_a[TAG_BITS-1:0];
	assign rd_key_b     = ram_rdata_b[WORD_W-1:TAG_BITS];

	assign result_valid = result_valid_q;
	assign sorted_key   = sorted_key_q;
	assign sorted_tag   = sorted_tag_q;
	assign final_result = final_result_q;

	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = count_q[IDX_BITS-1:0];
		ram_wdata   = {key_in, tag_in};
		ram_raddr_a = sw_a_q;
		stk_we      = 1'b0;
		stk_waddr   = sp_q[IDX_BITS-1:0];
		stk_wdata   = {last_inc, hi_q};
		stk_raddr   = IDX_BITS'(sp_q - CNT_BITS'(1));
		unique case (state_q)
			S_LOAD: begin
				ram_we = item_acc && has_room;
				if (item_acc && last_item && (n_next > CNT_BITS'(1))) begin
					stk_we    = 1'b1;
					stk_waddr = '0;
					stk_wdata = {IDX_BITS'(0), IDX_BITS'(n_next - CNT_BITS'(1))};
				end
			end
			S_SW_W1: begin
				ram_we    = 1'b1;
				ram_waddr = sw_a_q;
				ram_wdata = ram_rdata_b;
			end
			S_SW_W2: begin
				ram_we    = 1'b1;
				ram_waddr = sw_b_q;
				ram_wdata = tmp_q;
			end
			S_SCAN: begin
				ram_raddr_a = k_q[IDX_BITS-1:0];
			end
			S_FINISH: begin
				stk_we = push_tail && (sp_q < CNT_BITS'(DEPTH));
			end
			S_OUT: begin
				ram_raddr_a = out_idx_q[IDX_BITS-1:0];
			end
			S_POP, S_POP_WAIT, S_RANGE, S_SW_RD, S_SCAN_CMP, S_OUT_WAIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			ret_q          <= S_LOAD;
			count_q        <= '0;
			n_q            <= '0;
			sp_q           <= '0;
			k_q            <= '0;
			out_idx_q      <= '0;
			lo_q           <= '0;
			hi_q           <= '0;
			last_q         <= '0;
			sw_a_q         <= '0;
			sw_b_q         <= '0;
			tmp_q          <= '0;
			pivot_q        <= '0;
			result_valid_q <= 1'b0;
			sorted_key_q   <= '0;
			sorted_tag_q   <= '0;
			final_result_q <= 1'b0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (item_acc) begin
						count_q <= n_next;
						if (last_item) begin
							count_q   <= '0;
							n_q       <= n_next;
							out_idx_q <= '0;
							if (n_next > CNT_BITS'(1)) begin
								sp_q    <= CNT_BITS'(1);
								state_q <= S_POP;
							end else begin
								sp_q    <= '0;
								state_q <= S_OUT;
							end
						end
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						out_idx_q <= '0;
						state_q   <= S_OUT;
					end else begin
						sp_q    <= sp_q - CNT_BITS'(1);
						state_q <= S_POP_WAIT;
					end
				end
				S_POP_WAIT: begin
					lo_q    <= stk_rdata[RANGE_W-1:IDX_BITS];
					hi_q    <= stk_rdata[IDX_BITS-1:0];
					state_q <= S_RANGE;
				end
				S_RANGE: begin
					if (lo_q < hi_q) begin
						sw_a_q  <= lo_q;
						sw_b_q  <= mid;
						last_q  <= lo_q;
						k_q     <= CNT_BITS'({1'b0, lo_q} + (IDX_BITS + 1)'(1));
						ret_q   <= S_SCAN;
						state_q <= S_SW_RD;
					end else begin
						state_q <= S_POP;
					end
				end
				S_SW_RD: begin
					state_q <= S_SW_W1;
				end
				S_SW_W1: begin
					tmp_q   <= ram_rdata_a;
					if (ret_q == S_SCAN && sw_a_q == lo_q) begin
						pivot_q <= rd_key_b;
					end
					state_q <= S_SW_W2;
				end
				S_SW_W2: begin
					state_q <= ret_q;
				end
				S_SCAN: begin
					if (k_q > CNT_BITS'(hi_q)) begin
						sw_a_q  <= lo_q;
						sw_b_q  <= last_q;
						ret_q   <= S_FINISH;
						state_q <= S_SW_RD;
					end else begin
						state_q <= S_SCAN_CMP;
					end
				end
				S_SCAN_CMP: begin
					k_q <= k_q + CNT_BITS'(1);
					if (rd_key_a < pivot_q) begin
						last_q  <= last_inc;
						sw_a_q  <= last_inc;
						sw_b_q  <= k_q[IDX_BITS-1:0];
						ret_q   <= S_SCAN;
						state_q <= S_SW_RD;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_FINISH: begin
					if (push_tail && (sp_q < CNT_BITS'(DEPTH))) begin
						sp_q <= sp_q + CNT_BITS'(1);
					end
					hi_q    <= last_q;
					state_q <= S_RANGE;
				end
				S_OUT: begin
					if (out_idx_q == n_q) begin
						state_q <= S_LOAD;
					end else if (!result_valid_q || result_ready) begin
						state_q <= S_OUT_WAIT;
					end
				end
				S_OUT_WAIT: begin
					result_valid_q <= 1'b1;
					sorted_key_q   <= kpqs_pkg::KEY_W'(rd_key_a);
					sorted_tag_q   <= kpqs_pkg::TAG_W'(rd_tag_a);
					final_result_q <= (out_idx_q == n_q - CNT_BITS'(1));
					out_idx_q      <= out_idx_q + CNT_BITS'(1);
					state_q        <= S_OUT;
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	kpqs_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (sw_b_q),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	kpqs_stack #(
		.WIDTH (RANGE_W),
		.DEPTH (DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

endmodule

`default_nettype wire

[rtl/kpqs_ram.sv]
// Item store: one write port and two registered read ports.
`default_nettype none

module kpqs_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

[rtl/kpqs_stack.sv]
// Range stack memory: one write port and one registered read port.
`default_nettype none

module kpqs_stack #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/kpqs_checker.sv]
// Port-level checks for the key/payload quicksort unit and their binding.
`default_nettype none

`include "key_payload_quicksort_unit_assert.svh"

module kpqs_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              item_valid,
	input wire logic                              item_ready,
	input wire logic signed [kpqs_pkg::KEY_W-1:0] key_value,
	input wire logic        [kpqs_pkg::TAG_W-1:0] tag_value,
	input wire logic                              last_item,
	input wire logic                              result_valid,
	input wire logic                              result_ready,
	input wire logic signed [kpqs_pkg::KEY_W-1:0] sorted_key,
	input wire logic        [kpqs_pkg::TAG_W-1:0] sorted_tag,
	input wire logic                              final_result
);

	// A stalled result keeps its contents.
	`KPQS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(sorted_key) && $stable(sorted_tag) && $stable(final_result))

	// A closing item stops intake while the set is sorted.
	`KPQS_ASSERT_NEXT(a_close_stalls_intake, item_valid && item_ready && last_item, !item_ready)

	// Intake stays closed while pairs of the run remain.
	`KPQS_ASSERT_NEXT(a_run_blocks_intake, result_valid && result_ready && !final_result, !item_ready)

	// Once the last pair is taken, nothing follows until a new set closes.
	`KPQS_ASSERT_NEXT(a_run_ends, result_valid && result_ready && final_result, !result_valid)

	// Key and tag inputs are only sampled under the handshake; the check bounds their set bits by their widths.
	`KPQS_ASSERT_NOW(a_tag_width, item_valid && item_ready, $countones(tag_value) <= kpqs_pkg::TAG_W && $countones(key_value) <= kpqs_pkg::KEY_W)

endmodule

bind key_payload_quicksort_unit kpqs_checker u_kpqs_checker (.*);

`default_nettype wire
